// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and a character class helper for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    // token kinds
    localparam logic [4:0] KIND_END      = 5'd0;
    localparam logic [4:0] KIND_LPAREN   = 5'd1;
    localparam logic [4:0] KIND_RPAREN   = 5'd2;
    localparam logic [4:0] KIND_DOT      = 5'd3;
    localparam logic [4:0] KIND_SEMI     = 5'd4;
    localparam logic [4:0] KIND_CARET    = 5'd5;
    localparam logic [4:0] KIND_ASSIGN   = 5'd6;
    localparam logic [4:0] KIND_BPARAM   = 5'd7;
    localparam logic [4:0] KIND_LBRACKET = 5'd8;
    localparam logic [4:0] KIND_RBRACKET = 5'd9;
    localparam logic [4:0] KIND_STRING   = 5'd10;
    localparam logic [4:0] KIND_SYMBOL   = 5'd11;
    localparam logic [4:0] KIND_INT      = 5'd12;
    localparam logic [4:0] KIND_KEYWORD  = 5'd13;
    localparam logic [4:0] KIND_IDENT    = 5'd14;
    localparam logic [4:0] KIND_BINARY   = 5'd15;
    localparam logic [4:0] KIND_ERROR    = 5'd16;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_STRING  = 2'd1;
    localparam logic [1:0] ERR_HASH    = 2'd2;
    localparam logic [1:0] ERR_UNEXPEC = 2'd3;

    // output character source
    localparam logic [1:0] CH_NONE  = 2'd0;
    localparam logic [1:0] CH_BYTE  = 2'd1;
    localparam logic [1:0] CH_COLON = 2'd2;
    localparam logic [1:0] CH_RDATA = 2'd3;

    // text store write index base
    localparam logic [1:0] BASE_LEN  = 2'd0;
    localparam logic [1:0] BASE_ZERO = 2'd1;
    localparam logic [1:0] BASE_ONE  = 2'd2;

    // text store write character
    localparam logic [1:0] WCH_BYTE  = 2'd0;
    localparam logic [1:0] WCH_COLON = 2'd1;
    localparam logic [1:0] WCH_MINUS = 2'd2;

    // length ops
    localparam logic [1:0] LEN_KEEP = 2'd0;
    localparam logic [1:0] LEN_CLR  = 2'd1;
    localparam logic [1:0] LEN_ONE  = 2'd2;

    // number ops
    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_POS  = 2'd1;
    localparam logic [1:0] NUM_NEG  = 2'd2;
    localparam logic [1:0] NUM_DIG  = 2'd3;

    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_MINUS = 8'h2D;

    // status from datapath to controller
    typedef struct packed {
        logic       is_end;
        logic       is_space;
        logic       is_digit;
        logic       is_name_start;
        logic       is_word;
        logic       is_binary;
        logic       is_colon;
        logic       is_quote;
        logic       is_hash;
        logic       is_eq;
        logic       is_minus;
        logic       is_punct;
        logic [4:0] punct_kind;
        logic       punct_eo;
        logic       len_zero;
        logic       rd_done;
        logic       out_free;
    } stt_stat_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       latch;
        logic       app_en;
        logic [1:0] app_base;
        logic [1:0] app_char;
        logic       app_nolen;
        logic [1:0] len_op;
        logic [1:0] num_op;
        logic       rd_clr;
        logic       rd_issue;
        logic       out_load;
        logic [4:0] out_kind;
        logic [1:0] out_chsel;
        logic [1:0] out_err;
        logic       out_num;
        logic       out_tlast;
        logic       out_rlast;
        logic       clr_all;
    } stt_cmd_t;

    function automatic logic is_binary_char(input logic [7:0] b);
        logic r;
        case (b)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h7E, 8'h3C, 8'h3E, 8'h3D,
            8'h26, 8'h7C, 8'h40, 8'h25, 8'h2C, 8'h3F, 8'h21, 8'h5C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/stt_ifs.sv -----
// ----------------------------------------------------------------------------
// stt_ifs
// Valid/ready channels for source bytes and token items.
// ----------------------------------------------------------------------------
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stt_out_if;
    logic               valid;
    logic               ready;
    logic        [4:0]  token_kind;
    logic        [7:0]  char_out;
    logic               char_valid;
    logic signed [63:0] int_value;
    logic        [1:0]  error_code;
    logic               token_last;
    logic               run_last;

    modport source (output valid, output token_kind, output char_out, output char_valid,
                    output int_value, output error_code, output token_last,
                    output run_last, input ready);
    modport sink   (input valid, input token_kind, input char_out, input char_valid,
                    input int_value, input error_code, input token_last,
                    input run_last, output ready);
endinterface

// ----- rtl/stt_dp.sv -----
// ----------------------------------------------------------------------------
// stt_dp
// Datapath: input byte register, text store, number accumulator, output reg.
// ----------------------------------------------------------------------------
module stt_dp #(
    parameter int TEXT_CAPACITY = 32,
    parameter int NUMBER_CHARS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stt_pkg::stt_cmd_t   cmd,
    output stt_pkg::stt_stat_t  stat,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [4:0]          out_kind,
    output logic [7:0]          out_char,
    output logic                out_char_valid,
    output logic signed [63:0]  out_int,
    output logic [1:0]          out_err,
    output logic                out_tlast,
    output logic                out_rlast
);
    import stt_pkg::*;

    localparam int LEN_W = $clog2(TEXT_CAPACITY);
    localparam int CNT_W = $clog2(NUMBER_CHARS);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TEXT_CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUMBER_CHARS - 1);
    localparam logic [63:0] CAP = 64'h8000_0000_0000_0000;

    logic [7:0]       byte_reg;
    logic             end_reg;
    logic [7:0]       mem [TEXT_CAPACITY];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [7:0]       rdata_reg;
    logic [63:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovalid_reg;
    logic [4:0]       okind_reg;
    logic [7:0]       ochar_reg;
    logic             ocv_reg;
    logic [63:0]      oint_reg;
    logic [1:0]       oerr_reg;
    logic             otl_reg;
    logic             orl_reg;

    logic [7:0]       eb;
    logic [LEN_W-1:0] base;
    logic             fit;
    logic [7:0]       wchar;
    logic [3:0]       dig;
    logic [67:0]      wide;
    logic [63:0]      nval;
    logic [7:0]       ochar;

    assign eb  = end_reg ? 8'd0 : byte_reg;
    assign dig = eb[3:0];

    // byte classes
    always_comb
    begin
        stat               = '0;
        stat.is_end        = end_reg || (byte_reg == 8'd0);
        stat.is_space      = (eb == 8'h20) || (eb >= 8'h09 && eb <= 8'h0D);
        stat.is_digit      = (eb >= 8'h30 && eb <= 8'h39);
        stat.is_name_start = (eb >= 8'h61 && eb <= 8'h7A) || (eb >= 8'h41 && eb <= 8'h5A)
                             || (eb == 8'h5F);
        stat.is_word       = stat.is_name_start || stat.is_digit;
        stat.is_binary     = is_binary_char(eb);
        stat.is_colon      = (eb == CHR_COLON);
        stat.is_quote      = (eb == 8'h27);
        stat.is_hash       = (eb == 8'h23);
        stat.is_eq         = (eb == 8'h3D);
        stat.is_minus      = (eb == CHR_MINUS);
        stat.is_punct      = 1'b1;
        stat.punct_eo      = 1'b1;
        case (eb)
            8'h28:   stat.punct_kind = KIND_LPAREN;
            8'h29:
            begin
                stat.punct_kind = KIND_RPAREN;
                stat.punct_eo   = 1'b0;
            end
            8'h2E:   stat.punct_kind = KIND_DOT;
            8'h3B:   stat.punct_kind = KIND_SEMI;
            8'h5E:   stat.punct_kind = KIND_CARET;
            8'h5B:   stat.punct_kind = KIND_LBRACKET;
            8'h5D:
            begin
                stat.punct_kind = KIND_RBRACKET;
                stat.punct_eo   = 1'b0;
            end
            default:
            begin
                stat.punct_kind = KIND_END;
                stat.is_punct   = 1'b0;
            end
        endcase
        stat.len_zero = (len_reg == '0);
        stat.rd_done  = (rd_idx_reg == len_reg);
        stat.out_free = !ovalid_reg || out_ready;
    end

    // text append
    always_comb
    begin
        unique case (cmd.app_base)
            BASE_ZERO: base = '0;
            BASE_ONE:  base = LEN_W'(1);
            default:   base = len_reg;
        endcase
        fit = (base < LEN_MAX);
        unique case (cmd.app_char)
            WCH_COLON: wchar = CHR_COLON;
            WCH_MINUS: wchar = CHR_MINUS;
            default:   wchar = byte_reg;
        endcase
        if (cmd.clr_all)
            len_next = '0;
        else if (cmd.app_en && !cmd.app_nolen)
            len_next = fit ? base + LEN_W'(1) : base;
        else if (cmd.len_op == LEN_CLR)
            len_next = '0;
        else if (cmd.len_op == LEN_ONE)
            len_next = LEN_W'(1);
        else
            len_next = len_reg;
    end

    // number accumulate, saturating at 2^63
    always_comb
    begin
        wide     = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {64'd0, dig};
        acc_next = acc_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (cmd.clr_all)
        begin
            acc_next = '0;
            neg_next = 1'b0;
            cnt_next = '0;
        end
        else
        begin
            unique case (cmd.num_op)
                NUM_POS:
                begin
                    acc_next = {60'd0, dig};
                    neg_next = 1'b0;
                    cnt_next = CNT_W'(1);
                end
                NUM_NEG:
                begin
                    neg_next = 1'b1;
                    if (NUMBER_CHARS > 2)
                    begin
                        acc_next = {60'd0, dig};
                        cnt_next = CNT_W'(2);
                    end
                    else
                    begin
                        acc_next = '0;
                        cnt_next = CNT_W'(1);
                    end
                end
                NUM_DIG:
                begin
                    if (cnt_reg < CNT_MAX)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        acc_next = (wide > {4'd0, CAP}) ? CAP : wide[63:0];
                    end
                end
                default: ;
            endcase
        end
        if (neg_reg)
            nval = acc_reg[63] ? CAP : (64'd0 - acc_reg);
        else
            nval = acc_reg[63] ? (CAP - 64'd1) : acc_reg;
        unique case (cmd.out_chsel)
            CH_BYTE:  ochar = byte_reg;
            CH_COLON: ochar = CHR_COLON;
            CH_RDATA: ochar = rdata_reg;
            default:  ochar = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            rd_idx_reg <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            acc_reg <= acc_next;
            neg_reg <= neg_next;
            cnt_reg <= cnt_next;
            if (cmd.rd_clr)
                rd_idx_reg <= '0;
            else if (cmd.rd_issue)
                rd_idx_reg <= rd_idx_reg + LEN_W'(1);
            if (cmd.out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg <= in_byte;
            end_reg  <= in_end;
        end
        if (cmd.app_en && fit)
            mem[base] <= wchar;
        if (cmd.rd_issue)
            rdata_reg <= mem[rd_idx_reg];
        if (cmd.out_load)
        begin
            okind_reg <= cmd.out_kind;
            ochar_reg <= ochar;
            ocv_reg   <= (cmd.out_chsel != CH_NONE);
            oint_reg  <= cmd.out_num ? nval : 64'd0;
            oerr_reg  <= cmd.out_err;
            otl_reg   <= cmd.out_tlast;
            orl_reg   <= cmd.out_rlast;
        end
    end

    assign out_valid      = ovalid_reg;
    assign out_kind       = okind_reg;
    assign out_char       = ochar_reg;
    assign out_char_valid = ocv_reg;
    assign out_int        = oint_reg;
    assign out_err        = oerr_reg;
    assign out_tlast      = otl_reg;
    assign out_rlast      = orl_reg;

endmodule

// ----- rtl/stt_ctrl.sv -----
// ----------------------------------------------------------------------------
// stt_ctrl
// Controller: scan mode tracking and sequencing of token emission.
// ----------------------------------------------------------------------------
module stt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  stt_pkg::stt_stat_t stat,
    output stt_pkg::stt_cmd_t  cmd
);
    import stt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONT = 3'd1;
    localparam logic [2:0] S_ASGL = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_TX   = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_COLON     = 4'd1;
    localparam logic [3:0] M_PARAM     = 4'd2;
    localparam logic [3:0] M_STRING    = 4'd3;
    localparam logic [3:0] M_QUOTE     = 4'd4;
    localparam logic [3:0] M_HASH      = 4'd5;
    localparam logic [3:0] M_SYMNAME   = 4'd6;
    localparam logic [3:0] M_SYMCOLON  = 4'd7;
    localparam logic [3:0] M_SYMBIN    = 4'd8;
    localparam logic [3:0] M_MINUS     = 4'd9;
    localparam logic [3:0] M_NUMBER    = 4'd10;
    localparam logic [3:0] M_NAME      = 4'd11;
    localparam logic [3:0] M_NAMECOLON = 4'd12;
    localparam logic [3:0] M_BINARY    = 4'd13;

    localparam logic [1:0] T_NONE   = 2'd0;
    localparam logic [1:0] T_START  = 2'd1;
    localparam logic [1:0] T_END    = 2'd2;
    localparam logic [1:0] T_ASSIGN = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [3:0] mode_reg, mode_next;
    logic       exp_reg, exp_next;
    logic       atext_reg, atext_next;
    logic [4:0] akind_reg, akind_next;
    logic [1:0] achsel_reg, achsel_next;
    logic [1:0] aerr_reg, aerr_next;
    logic       anum_reg, anum_next;
    logic       arl_reg, arl_next;
    logic [1:0] tail_reg, tail_next;

    logic       a_en;
    logic       taken;
    logic       to_assign;

    function automatic logic start_emits(input stt_stat_t s, input logic eo);
        return !s.is_space && (s.is_punct || !(s.is_colon || s.is_quote || s.is_hash
               || s.is_digit || (s.is_minus && eo) || s.is_name_start || s.is_binary));
    endfunction

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        mode_next   = mode_reg;
        exp_next    = exp_reg;
        atext_next  = atext_reg;
        akind_next  = akind_reg;
        achsel_next = achsel_reg;
        aerr_next   = aerr_reg;
        anum_next   = anum_reg;
        arl_next    = arl_reg;
        tail_next   = tail_reg;
        a_en        = 1'b0;
        taken       = 1'b0;
        to_assign   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CONT;
                end
            end

            S_CONT:
            begin
                atext_next  = 1'b0;
                achsel_next = CH_NONE;
                aerr_next   = ERR_NONE;
                anum_next   = 1'b0;
                if (stat.is_end && mode_reg == M_STRING)
                begin
                    a_en       = 1'b1;
                    akind_next = KIND_ERROR;
                    aerr_next  = ERR_STRING;
                end
                else if (mode_reg == M_IDLE)
                begin
                    taken = 1'b0;
                end
                else
                begin
                    case (mode_reg)
                        M_MINUS:
                        begin
                            if (stat.is_digit)
                            begin
                                cmd.num_op = NUM_NEG;
                                mode_next  = M_NUMBER;
                                taken      = 1'b1;
                            end
                            else if (stat.is_binary)
                            begin
                                cmd.app_en   = 1'b1;
                                cmd.app_base = BASE_ONE;
                                mode_next    = M_BINARY;
                                taken        = 1'b1;
                            end
                            else
                            begin
                                cmd.len_op = LEN_ONE;
                                a_en       = 1'b1;
                                atext_next = 1'b1;
                                akind_next = KIND_BINARY;
                                exp_next   = 1'b1;
                            end
                        end
                        M_COLON:
                        begin
                            if (stat.is_eq)
                            begin
                                a_en       = 1'b1;
                                akind_next = KIND_ASSIGN;
                                exp_next   = 1'b1;
                                mode_next  = M_IDLE;
                                taken      = 1'b1;
                            end
                            else if (stat.is_name_start)
                            begin
                                cmd.app_en = 1'b1;
                                mode_next  = M_PARAM;
                                taken      = 1'b1;
                            end
                            else
                            begin
                                a_en        = 1'b1;
                                akind_next  = KIND_ERROR;
                                achsel_next = CH_COLON;
                                aerr_next   = ERR_UNEXPEC;
                            end
                        end
                        M_PARAM:
                        begin
                            if (stat.is_word)
                            begin
                                cmd.app_en = 1'b1;
                                taken      = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                atext_next = 1'b1;
                                akind_next = KIND_BPARAM;
                                exp_next   = 1'b0;
                            end
                        end
                        M_STRING:
                        begin
                            taken = 1'b1;
                            if (stat.is_quote)
                                mode_next = M_QUOTE;
                            else
                                cmd.app_en = 1'b1;
                        end
                        M_QUOTE:
                        begin
                            if (stat.is_quote)
                            begin
                                cmd.app_en = 1'b1;
                                mode_next  = M_STRING;
                                taken      = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                atext_next = 1'b1;
                                akind_next = KIND_STRING;
                                exp_next   = 1'b0;
                            end
                        end
                        M_HASH:
                        begin
                            if (stat.is_name_start)
                            begin
                                cmd.app_en = 1'b1;
                                mode_next  = M_SYMNAME;
                                taken      = 1'b1;
                            end
                            else if (stat.is_binary)
                            begin
                                cmd.app_en = 1'b1;
                                mode_next  = M_SYMBIN;
                                taken      = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                akind_next = KIND_ERROR;
                                aerr_next  = ERR_HASH;
                            end
                        end
                        M_SYMNAME, M_SYMCOLON, M_SYMBIN:
                        begin
                            if ((mode_reg == M_SYMNAME && stat.is_word)
                                || (mode_reg == M_SYMBIN && stat.is_binary))
                            begin
                                cmd.app_en = 1'b1;
                                taken      = 1'b1;
                            end
                            else if (mode_reg == M_SYMNAME && stat.is_colon)
                            begin
                                cmd.app_en = 1'b1;
                                mode_next  = M_SYMCOLON;
                                taken      = 1'b1;
                            end
                            else if (mode_reg == M_SYMCOLON && stat.is_name_start)
                            begin
                                cmd.app_en = 1'b1;
                                mode_next  = M_SYMNAME;
                                taken      = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                atext_next = 1'b1;
                                akind_next = KIND_SYMBOL;
                                exp_next   = 1'b0;
                            end
                        end
                        M_NUMBER:
                        begin
                            if (stat.is_digit)
                            begin
                                cmd.num_op = NUM_DIG;
                                taken      = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                akind_next = KIND_INT;
                                anum_next  = 1'b1;
                                exp_next   = 1'b0;
                            end
                        end
                        M_NAME:
                        begin
                            if (stat.is_word)
                            begin
                                cmd.app_en = 1'b1;
                                taken      = 1'b1;
                            end
                            else if (stat.is_colon)
                            begin
                                mode_next = M_NAMECOLON;
                                taken     = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                atext_next = 1'b1;
                                akind_next = KIND_IDENT;
                                exp_next   = 1'b0;
                            end
                        end
                        M_NAMECOLON:
                        begin
                            a_en       = 1'b1;
                            atext_next = 1'b1;
                            exp_next   = 1'b1;
                            if (stat.is_eq)
                            begin
                                // identifier followed by :=
                                akind_next = KIND_IDENT;
                                mode_next  = M_IDLE;
                                taken      = 1'b1;
                                to_assign  = 1'b1;
                            end
                            else
                            begin
                                cmd.app_en   = 1'b1;
                                cmd.app_char = WCH_COLON;
                                akind_next   = KIND_KEYWORD;
                            end
                        end
                        M_BINARY:
                        begin
                            if (stat.is_binary)
                            begin
                                cmd.app_en = 1'b1;
                                taken      = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                atext_next = 1'b1;
                                akind_next = KIND_BINARY;
                                exp_next   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end

                if (stat.is_end)
                    tail_next = T_END;
                else if (to_assign)
                    tail_next = T_ASSIGN;
                else if (taken)
                    tail_next = T_NONE;
                else
                    tail_next = T_START;

                arl_next = (tail_next == T_NONE)
                           || (tail_next == T_START && !start_emits(stat, exp_next));
                state_next = a_en ? S_ASGL : S_TAIL;
            end

            S_ASGL:
            begin
                if (atext_reg && !stat.len_zero)
                begin
                    cmd.rd_clr = 1'b1;
                    state_next = S_RD;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = akind_reg;
                    cmd.out_chsel = achsel_reg;
                    cmd.out_err   = aerr_reg;
                    cmd.out_num   = anum_reg;
                    cmd.out_tlast = 1'b1;
                    cmd.out_rlast = arl_reg;
                    state_next    = S_TAIL;
                end
            end

            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_TX;
            end

            S_TX:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = akind_reg;
                    cmd.out_chsel = CH_RDATA;
                    cmd.out_tlast = stat.rd_done;
                    cmd.out_rlast = stat.rd_done && arl_reg;
                    state_next    = stat.rd_done ? S_TAIL : S_RD;
                end
            end

            S_TAIL:
            begin
                case (tail_reg)
                    T_END:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.out_load  = 1'b1;
                            cmd.out_kind  = KIND_END;
                            cmd.out_tlast = 1'b1;
                            cmd.out_rlast = 1'b1;
                            cmd.clr_all   = 1'b1;
                            mode_next     = M_IDLE;
                            exp_next      = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    T_ASSIGN:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.out_load  = 1'b1;
                            cmd.out_kind  = KIND_ASSIGN;
                            cmd.out_tlast = 1'b1;
                            cmd.out_rlast = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    T_START:
                    begin
                        if (!start_emits(stat, exp_reg) || stat.out_free)
                        begin
                            cmd.len_op    = LEN_CLR;
                            cmd.out_tlast = 1'b1;
                            cmd.out_rlast = 1'b1;
                            mode_next     = M_IDLE;
                            state_next    = S_IDLE;
                            if (stat.is_space)
                                mode_next = M_IDLE;
                            else if (stat.is_punct)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = stat.punct_kind;
                                exp_next     = stat.punct_eo;
                            end
                            else if (stat.is_colon)
                                mode_next = M_COLON;
                            else if (stat.is_quote)
                                mode_next = M_STRING;
                            else if (stat.is_hash)
                                mode_next = M_HASH;
                            else if (stat.is_digit)
                            begin
                                cmd.num_op = NUM_POS;
                                mode_next  = M_NUMBER;
                            end
                            else if (stat.is_minus && exp_reg)
                            begin
                                // park the '-' at the head of the store, length stays 0
                                cmd.app_en    = 1'b1;
                                cmd.app_base  = BASE_ZERO;
                                cmd.app_char  = WCH_MINUS;
                                cmd.app_nolen = 1'b1;
                                mode_next     = M_MINUS;
                            end
                            else if (stat.is_name_start || stat.is_binary)
                            begin
                                cmd.app_en   = 1'b1;
                                cmd.app_base = BASE_ZERO;
                                mode_next    = stat.is_name_start ? M_NAME : M_BINARY;
                            end
                            else
                            begin
                                cmd.out_load  = 1'b1;
                                cmd.out_kind  = KIND_ERROR;
                                cmd.out_chsel = CH_BYTE;
                                cmd.out_err   = ERR_UNEXPEC;
                            end
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= M_IDLE;
            exp_reg   <= 1'b1;
            tail_reg  <= T_NONE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            exp_reg   <= exp_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        atext_reg  <= atext_next;
        akind_reg  <= akind_next;
        achsel_reg <= achsel_next;
        aerr_reg   <= aerr_next;
        anum_reg   <= anum_next;
        arl_reg    <= arl_next;
    end

endmodule

// ----- rtl/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Flow: a taken byte is latched into the byte register and classified in the
//   scan state; its result items are then loaded into the output register. A
//   new byte is taken only once the controller is back in its idle state,
//   after all items of the previous byte are loaded; output stalls hold it.
// Token text goes out one character at a time (text store read port, then
//   output register); single items are loaded straight into the output reg.
// Reset: rst_n clears control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int TEXT_CAPACITY = 32,
    parameter int NUMBER_CHARS  = 32
) (
    input logic       clk,
    input logic       rst_n,
    stt_in_if.sink    in_ch,
    stt_out_if.source out_ch
);
    import stt_pkg::*;

    stt_cmd_t  cmd;
    stt_stat_t stat;

    // controller: scan mode, look-ahead decisions, emission sequencing
    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: byte classes, text store, number accumulator, output stage
    stt_dp #(
        .TEXT_CAPACITY (TEXT_CAPACITY),
        .NUMBER_CHARS  (NUMBER_CHARS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_byte        (in_ch.text_byte),
        .in_end         (in_ch.end_of_text),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .out_kind       (out_ch.token_kind),
        .out_char       (out_ch.char_out),
        .out_char_valid (out_ch.char_valid),
        .out_int        (out_ch.int_value),
        .out_err        (out_ch.error_code),
        .out_tlast      (out_ch.token_last),
        .out_rlast      (out_ch.run_last)
    );

`ifndef SYNTHESIS
    // a byte transaction always starts a scan cycle, so the port closes
    a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input still open after transaction");

    // the last item of a run always closes a token
    a_run_tok: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.run_last |-> out_ch.token_last)
        else $error("run_last without token_last");

    // only integer tokens carry a value
    a_int_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.token_kind != KIND_INT |-> out_ch.int_value == 64'sd0)
        else $error("value on non-integer token");
`endif

endmodule

// ----- tb/tb_source_text_tokenizer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Feeds source text into the tokenizer and checks every token item it sends
// back against a scanner model kept in this bench. Text is sent as directed
// fragments, then as random token-shaped text mixed with random noise bytes.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
    import stt_pkg::*;

    // scanner states, one per pending token shape
    typedef enum int {
        SC_IDLE, SC_COLON, SC_PARAM, SC_STRING, SC_QUOTE, SC_HASH, SC_SYMNAME,
        SC_SYMCOLON, SC_SYMBIN, SC_MINUS, SC_NUMBER, SC_NAME, SC_NAMECOLON, SC_BINARY
    } scan_state_e;

    localparam int TEXT_CAP  = 32;
    localparam int NUM_CHARS = 32;
    localparam logic [63:0] CAP64 = 64'h8000_0000_0000_0000;

    // one result item as it leaves the block
    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  ch;
        logic        chv;
        logic [63:0] ival;
        logic [1:0]  err;
        logic        tlast;
        logic        rlast;
    } token_item_t;

    // one source byte with its end flag
    typedef struct packed {
        logic [7:0] b;
        logic       eot;
    } src_byte_t;

    logic clk;
    logic rst_n;

    stt_in_if  in_ch();
    stt_out_if out_ch();

    source_text_tokenizer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // --------------------------------------------------------------------
    // Scanner model state
    // --------------------------------------------------------------------
    scan_state_e sc_mode;
    logic        sc_operand;
    logic [7:0]  sc_text [TEXT_CAP];
    int          sc_len;
    logic [63:0] sc_acc;
    logic        sc_neg;
    int          sc_digits;

    token_item_t expected_items[$];
    token_item_t step_items[$];
    src_byte_t   pending_bytes[$];

    int  errors;
    int  bytes_sent;
    int  items_checked;
    bit  stim_done;
    bit  hold_sink;
    bit  hold_source;

    function automatic bit is_ws(logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction
    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic bit is_nstart(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction
    function automatic bit is_wordch(logic [7:0] b);
        return is_nstart(b) || is_dig(b);
    endfunction
    function automatic bit is_binop(logic [7:0] b);
        return b == "+" || b == "-" || b == "*" || b == "/" || b == "~" || b == "<" ||
               b == ">" || b == "=" || b == "&" || b == "|" || b == "@" || b == "%" ||
               b == "," || b == "?" || b == "!" || b == 8'h5C;
    endfunction

    function automatic void push_item(logic [4:0] kind, logic [7:0] ch, logic chv,
                                      logic [63:0] ival, logic [1:0] err, logic tl);
        token_item_t it;
        it = '{kind: kind, ch: ch, chv: chv, ival: ival, err: err, tlast: tl, rlast: 1'b0};
        if (step_items.size() < 33)
            step_items.push_back(it);
    endfunction

    function automatic void keep_char(logic [7:0] b);
        if (sc_len < TEXT_CAP - 1)
        begin
            sc_text[sc_len] = b;
            sc_len++;
        end
    endfunction

    // whole buffered text as one token, or a single empty item
    function automatic void flush_text(logic [4:0] kind);
        if (sc_len == 0)
            push_item(kind, 8'd0, 1'b0, 64'd0, ERR_NONE, 1'b1);
        else
            for (int i = 0; i < sc_len; i++)
                push_item(kind, sc_text[i], 1'b1, 64'd0, ERR_NONE, i == sc_len - 1);
    endfunction

    function automatic void single(logic [4:0] kind, logic eo);
        push_item(kind, 8'd0, 1'b0, 64'd0, ERR_NONE, 1'b1);
        sc_operand = eo;
    endfunction

    function automatic void add_numchar(logic [7:0] b);
        logic [63:0] d;
        if (sc_digits >= NUM_CHARS - 1)
            return;
        sc_digits++;
        if (!is_dig(b))
            return;
        d = 64'(b - "0");
        if (sc_acc > (CAP64 - d) / 10)
            sc_acc = CAP64;
        else
            sc_acc = sc_acc * 10 + d;
    endfunction

    function automatic void flush_number();
        logic [63:0] v;
        if (sc_neg)
            v = (sc_acc >= CAP64) ? CAP64 : -sc_acc;
        else
            v = (sc_acc >= CAP64) ? CAP64 - 1 : sc_acc;
        push_item(KIND_INT, 8'd0, 1'b0, v, ERR_NONE, 1'b1);
        sc_operand = 1'b0;
    endfunction

    task automatic scan_reset();
        sc_mode    = SC_IDLE;
        sc_operand = 1'b1;
        sc_len     = 0;
        sc_acc     = '0;
        sc_neg     = 1'b0;
        sc_digits  = 0;
    endtask

    task automatic begin_token(logic [7:0] b);
        sc_mode = SC_IDLE;
        sc_len  = 0;
        if (is_ws(b))
            return;
        case (b)
            "(":   single(KIND_LPAREN, 1'b1);
            ")":   single(KIND_RPAREN, 1'b0);
            ".":   single(KIND_DOT, 1'b1);
            ";":   single(KIND_SEMI, 1'b1);
            "^":   single(KIND_CARET, 1'b1);
            "[":   single(KIND_LBRACKET, 1'b1);
            "]":   single(KIND_RBRACKET, 1'b0);
            ":":   sc_mode = SC_COLON;
            "'":   sc_mode = SC_STRING;
            "#":   sc_mode = SC_HASH;
            default:
            begin
                if (is_dig(b))
                begin
                    sc_acc = '0;
                    sc_neg = 1'b0;
                    sc_digits = 0;
                    add_numchar(b);
                    sc_mode = SC_NUMBER;
                end
                else if (b == "-" && sc_operand)
                    sc_mode = SC_MINUS;
                else if (is_nstart(b))
                begin
                    keep_char(b);
                    sc_mode = SC_NAME;
                end
                else if (is_binop(b))
                begin
                    keep_char(b);
                    sc_mode = SC_BINARY;
                end
                else
                    push_item(KIND_ERROR, b, 1'b1, 64'd0, ERR_UNEXPEC, 1'b1);
            end
        endcase
    endtask

    // returns 1 when the byte was absorbed by the pending token
    function automatic bit extend_token(logic [7:0] b);
        if (sc_mode == SC_MINUS)
        begin
            if (is_dig(b))
            begin
                sc_acc = '0;
                sc_neg = 1'b1;
                sc_digits = 0;
                add_numchar(CHR_MINUS);
                add_numchar(b);
                sc_mode = SC_NUMBER;
                return 1;
            end
            sc_len = 0;
            keep_char(CHR_MINUS);
            sc_mode = SC_BINARY;
        end
        case (sc_mode)
            SC_COLON:
            begin
                if (b == "=")
                begin
                    single(KIND_ASSIGN, 1'b1);
                    sc_mode = SC_IDLE;
                    return 1;
                end
                if (is_nstart(b))
                begin
                    keep_char(b);
                    sc_mode = SC_PARAM;
                    return 1;
                end
                push_item(KIND_ERROR, CHR_COLON, 1'b1, 64'd0, ERR_UNEXPEC, 1'b1);
                return 0;
            end
            SC_PARAM:
            begin
                if (is_wordch(b))
                begin
                    keep_char(b);
                    return 1;
                end
                flush_text(KIND_BPARAM);
                sc_operand = 1'b0;
                return 0;
            end
            SC_STRING:
            begin
                if (b == "'")
                    sc_mode = SC_QUOTE;
                else
                    keep_char(b);
                return 1;
            end
            SC_QUOTE:
            begin
                if (b == "'")
                begin
                    keep_char(b);
                    sc_mode = SC_STRING;
                    return 1;
                end
                flush_text(KIND_STRING);
                sc_operand = 1'b0;
                return 0;
            end
            SC_HASH:
            begin
                if (is_nstart(b))
                begin
                    keep_char(b);
                    sc_mode = SC_SYMNAME;
                    return 1;
                end
                if (is_binop(b))
                begin
                    keep_char(b);
                    sc_mode = SC_SYMBIN;
                    return 1;
                end
                push_item(KIND_ERROR, 8'd0, 1'b0, 64'd0, ERR_HASH, 1'b1);
                return 0;
            end
            SC_SYMNAME:
            begin
                if (is_wordch(b))
                begin
                    keep_char(b);
                    return 1;
                end
                if (b == ":")
                begin
                    keep_char(b);
                    sc_mode = SC_SYMCOLON;
                    return 1;
                end
            end
            SC_SYMCOLON:
            begin
                if (is_nstart(b))
                begin
                    keep_char(b);
                    sc_mode = SC_SYMNAME;
                    return 1;
                end
            end
            SC_SYMBIN:
            begin
                if (is_binop(b))
                begin
                    keep_char(b);
                    return 1;
                end
            end
            SC_NUMBER:
            begin
                if (is_dig(b))
                begin
                    add_numchar(b);
                    return 1;
                end
                flush_number();
                return 0;
            end
            SC_NAME:
            begin
                if (is_wordch(b))
                begin
                    keep_char(b);
                    return 1;
                end
                if (b == ":")
                begin
                    sc_mode = SC_NAMECOLON;
                    return 1;
                end
                flush_text(KIND_IDENT);
                sc_operand = 1'b0;
                return 0;
            end
            SC_NAMECOLON:
            begin
                if (b == "=")
                begin
                    flush_text(KIND_IDENT);
                    single(KIND_ASSIGN, 1'b1);
                    sc_mode = SC_IDLE;
                    return 1;
                end
                keep_char(CHR_COLON);
                flush_text(KIND_KEYWORD);
                sc_operand = 1'b1;
                return 0;
            end
            SC_BINARY:
            begin
                if (is_binop(b))
                begin
                    keep_char(b);
                    return 1;
                end
                flush_text(KIND_BINARY);
                sc_operand = 1'b1;
                return 0;
            end
            default:
                return 0;
        endcase
        // symbol forms fall out here
        flush_text(KIND_SYMBOL);
        sc_operand = 1'b0;
        return 0;
    endfunction

    // model one accepted byte; appends its items to the expected queue
    task automatic predict_byte(src_byte_t sb);
        bit taken;
        step_items.delete();
        if (sb.eot || sb.b == 8'd0)
        begin
            if (sc_mode == SC_STRING)
                push_item(KIND_ERROR, 8'd0, 1'b0, 64'd0, ERR_STRING, 1'b1);
            else if (sc_mode != SC_IDLE)
                taken = extend_token(8'd0);
            push_item(KIND_END, 8'd0, 1'b0, 64'd0, ERR_NONE, 1'b1);
            scan_reset();
        end
        else if (sc_mode == SC_IDLE)
            begin_token(sb.b);
        else if (!extend_token(sb.b))
            begin_token(sb.b);
        if (step_items.size() > 0)
            step_items[step_items.size() - 1].rlast = 1'b1;
        foreach (step_items[i])
            expected_items.push_back(step_items[i]);
    endtask

    // --------------------------------------------------------------------
    // Stimulus helpers: queue bytes for the driver
    // --------------------------------------------------------------------
    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back('{b: s[i], eot: 1'b0});
    endtask
    task automatic send_byte(logic [7:0] b, logic eot);
        pending_bytes.push_back('{b: b, eot: eot});
    endtask

    function automatic logic [7:0] rnd_alpha();
        return (($urandom_range(0, 1) == 1) ? "a" : "A") + 8'($urandom_range(0, 25));
    endfunction
    function automatic logic [7:0] rnd_binop();
        string s;
        s = "+-*/~<>=&|@%,?!\\";
        return s[$urandom_range(0, 15)];
    endfunction
    function automatic logic [7:0] rnd_word();
        case ($urandom_range(0, 3))
            0: return "0" + 8'($urandom_range(0, 9));
            1: return "_";
            default: return rnd_alpha();
        endcase
    endfunction
    // length: mostly short, sometimes past the text capacity
    function automatic int rnd_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
    endfunction

    // one well-formed token of random shape, sometimes followed by a whitespace separator
    task automatic send_random_token();
        int n;
        n = rnd_len();
        case ($urandom_range(0, 11))
            0:  send_byte("(" , 1'b0);
            1:  send_byte(($urandom_range(0, 1) == 1) ? ")" : "]", 1'b0);
            2:  send_str(($urandom_range(0, 1) == 1) ? ":=" : ".");
            3:
            begin
                send_byte(":", 1'b0);
                send_byte(rnd_alpha(), 1'b0);
                repeat (n) send_byte(rnd_word(), 1'b0);
            end
            4:
            begin
                send_byte("'", 1'b0);
                repeat (n)
                    if ($urandom_range(0, 7) == 0)
                        send_str("''");
                    else
                        send_byte(8'($urandom_range(1, 255)), 1'b0);
                send_byte("'", 1'b0);
            end
            5:
            begin
                send_byte("#", 1'b0);
                if ($urandom_range(0, 2) == 0)
                    repeat (n) send_byte(rnd_binop(), 1'b0);
                else
                    repeat ($urandom_range(1, 3))
                    begin
                        send_byte(rnd_alpha(), 1'b0);
                        repeat (n) send_byte(rnd_word(), 1'b0);
                        if ($urandom_range(0, 1) == 1)
                            send_byte(":", 1'b0);
                    end
            end
            6, 7:
            begin
                if ($urandom_range(0, 1) == 1)
                    send_byte("-", 1'b0);
                repeat (($urandom_range(0, 5) == 0) ? $urandom_range(18, 40) : n)
                    send_byte("0" + 8'($urandom_range(0, 9)), 1'b0);
            end
            8, 9:
            begin
                send_byte(rnd_alpha(), 1'b0);
                repeat (n - 1) send_byte(rnd_word(), 1'b0);
                if ($urandom_range(0, 2) == 0)
                    send_byte(":", 1'b0);
            end
            default:
                repeat (($urandom_range(0, 1) == 1) ? 1 : n) send_byte(rnd_binop(), 1'b0);
        endcase
        if ($urandom_range(0, 2) == 0)
            send_byte(8'(($urandom_range(0, 1) == 1) ? 32 : $urandom_range(9, 13)), 1'b0);
    endtask

    function automatic int rnd_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // --------------------------------------------------------------------
    // Driver: pops pending bytes, random gaps between transactions
    // --------------------------------------------------------------------
    int src_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.text_byte   <= 8'd0;
            in_ch.end_of_text <= 1'b0;
            src_gap           = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_byte('{b: in_ch.text_byte, eot: in_ch.end_of_text});
                bytes_sent++;
                src_gap = rnd_gap();
            end
            if (in_ch.valid && !in_ch.ready)
                ; // hold the offered byte
            else if (src_gap > 0)
            begin
                src_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0 && !hold_source)
            begin
                src_byte_t sb;
                sb = pending_bytes.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.text_byte   <= sb.b;
                in_ch.end_of_text <= sb.eot;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // --------------------------------------------------------------------
    // Monitor: checks each accepted item, randomly stalls ready
    // --------------------------------------------------------------------
    int sink_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_gap     = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                token_item_t exp_it;
                items_checked++;
                if (expected_items.size() == 0)
                begin
                    $error("unexpected item: kind %0d char %0h", out_ch.token_kind,
                           out_ch.char_out);
                    errors++;
                end
                else
                begin
                    exp_it = expected_items.pop_front();
                    if (out_ch.token_kind !== exp_it.kind)
                    begin
                        $error("token_kind: expected %0d, got %0d", exp_it.kind,
                               out_ch.token_kind);
                        errors++;
                    end
                    if (out_ch.char_out !== exp_it.ch)
                    begin
                        $error("char_out: expected %0h, got %0h", exp_it.ch, out_ch.char_out);
                        errors++;
                    end
                    if (out_ch.char_valid !== exp_it.chv)
                    begin
                        $error("char_valid: expected %0b, got %0b", exp_it.chv,
                               out_ch.char_valid);
                        errors++;
                    end
                    if (out_ch.int_value !== exp_it.ival)
                    begin
                        $error("int_value: expected %0d, got %0d", $signed(exp_it.ival),
                               out_ch.int_value);
                        errors++;
                    end
                    if (out_ch.error_code !== exp_it.err)
                    begin
                        $error("error_code: expected %0d, got %0d", exp_it.err,
                               out_ch.error_code);
                        errors++;
                    end
                    if (out_ch.token_last !== exp_it.tlast)
                    begin
                        $error("token_last: expected %0b, got %0b", exp_it.tlast,
                               out_ch.token_last);
                        errors++;
                    end
                    if (out_ch.run_last !== exp_it.rlast)
                    begin
                        $error("run_last: expected %0b, got %0b", exp_it.rlast,
                               out_ch.run_last);
                        errors++;
                    end
                end
            end
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready)
                    sink_gap = rnd_gap();
            end
        end
    end

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial
    begin
        int drained;
        errors = 0;
        bytes_sent = 0;
        items_checked = 0;
        stim_done = 0;
        hold_sink = 0;
        hold_source = 0;
        scan_reset();
        in_ch.valid = 1'b0;
        in_ch.text_byte = 8'd0;
        in_ch.end_of_text = 1'b0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: punctuation, assign, lone colon, keywords, strings, symbols
        send_str("( ) . ; ^ [ ] a:=3 :p1 : 9 foo: 'it''s' '' #at:put: #+ #( x-1");
        send_str(" -9223372036854775809 99999999999999999999 \x80\xff\x01 '");
        send_byte(8'd0, 1'b0);   // open string ended by a zero byte
        send_str("#");
        send_byte("q", 1'b1);    // end flag with a junk byte
        send_str("\x7f~");

        // random: mostly token-shaped text, some noise, some end marks
        for (int i = 0; i < 200; )
        begin
            int before_cnt;
            before_cnt = pending_bytes.size();
            case ($urandom_range(0, 19))
                0:       send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                1, 2:    send_byte(8'($urandom_range(1, 255)), 1'b0);
                default: send_random_token();
            endcase
            i += pending_bytes.size() - before_cnt;
            // output side holds off long so the block backs up
            if (i >= 80 && !hold_sink)
            begin
                hold_sink = 1;
                fork
                begin
                    repeat (400) @(posedge clk);
                    hold_sink = 0;
                end
                join_none
            end
        end
        // source pause until everything so far is out
        wait (pending_bytes.size() < 150);
        hold_source = 1;
        wait (pending_bytes.size() > 0 && expected_items.size() == 0 && !in_ch.valid);
        hold_source = 0;
        send_byte(8'd0, 1'b1);

        wait (pending_bytes.size() == 0 && !in_ch.valid);
        drained = 0;
        while (expected_items.size() != 0 && drained < 20000)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (40) @(posedge clk);
        $display("Sent %0d source bytes, checked %0d token items", bytes_sent, items_checked);
        $display("Covered punctuation, strings, symbols, integers, names and errors");
        if (errors == 0 && expected_items.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
